>>> sv/mmra_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// shared constants and types for the trimmed mean block
// used by the accumulator, the serial divider and the top level

package mmra_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int MAX_SAMPLES = 256;
    localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W       = SAMPLE_BITS + $clog2(MAX_SAMPLES);
    localparam int MEAN_W      = 16;
    localparam int MIN_COUNT   = 3;
    localparam int TRIM_COUNT  = 2;
    localparam int NUM_W       = SUM_W + 2;
    localparam int DEN_W       = COUNT_W + 1;
    localparam int STEP_W      = $clog2(NUM_W);

    typedef struct packed {
        logic [COUNT_W-1:0]     count;
        logic [SAMPLE_BITS-1:0] min_val;
        logic [SAMPLE_BITS-1:0] max_val;
        logic [SUM_W-1:0]       sum;
    } stats_t;

endpackage

`default_nettype wire

>>> sv/mmra_accum.sv
`timescale 1ns / 1ps
`default_nettype none
// running count, minimum, maximum and sum of the current set
// depends on mmra_pkg

module mmra_accum (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            accept,
    input  wire logic                            last,
    input  wire logic [mmra_pkg::SAMPLE_BITS-1:0] sample,
    output mmra_pkg::stats_t                     stats
);

    logic [mmra_pkg::COUNT_W-1:0]     count_reg;
    logic [mmra_pkg::SAMPLE_BITS-1:0] min_reg;
    logic [mmra_pkg::SAMPLE_BITS-1:0] max_reg;
    logic [mmra_pkg::SUM_W-1:0]       sum_reg;
    mmra_pkg::stats_t                 stats_next;

    // stats including the word offered this cycle
    always_comb begin
        stats_next.count   = count_reg;
        stats_next.min_val = min_reg;
        stats_next.max_val = max_reg;
        stats_next.sum     = sum_reg;
        if (count_reg < mmra_pkg::COUNT_W'(mmra_pkg::MAX_SAMPLES)) begin
            stats_next.count = count_reg + 1'b1;
            stats_next.sum   = sum_reg + mmra_pkg::SUM_W'(sample);
            if (sample < min_reg) begin
                stats_next.min_val = sample;
            end
            if (sample > max_reg) begin
                stats_next.max_val = sample;
            end
        end
    end

    assign stats = stats_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            min_reg   <= '1;
            max_reg   <= '0;
            sum_reg   <= '0;
        end else if (accept) begin
            if (last) begin
                count_reg <= '0;
                min_reg   <= '1;
                max_reg   <= '0;
                sum_reg   <= '0;
            end else begin
                count_reg <= stats_next.count;
                min_reg   <= stats_next.min_val;
                max_reg   <= stats_next.max_val;
                sum_reg   <= stats_next.sum;
            end
        end
    end

endmodule

`default_nettype wire

>>> sv/mmra_divider.sv
`timescale 1ns / 1ps
`default_nettype none
// restoring divider, one quotient bit per cycle
// depends on mmra_pkg

module mmra_divider (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [mmra_pkg::NUM_W-1:0] numerator,
    input  wire logic [mmra_pkg::DEN_W-1:0] divisor,
    output logic                            done,
    output logic [mmra_pkg::MEAN_W-1:0]     quotient
);

    logic                            busy_reg;
    logic                            done_reg;
    logic [mmra_pkg::STEP_W-1:0]     cnt_reg;
    logic [mmra_pkg::NUM_W-1:0]      num_reg;
    logic [mmra_pkg::MEAN_W-1:0]     quo_reg;
    logic [mmra_pkg::DEN_W-1:0]      den_reg;
    logic [mmra_pkg::DEN_W-1:0]      rem_reg;
    logic [mmra_pkg::DEN_W:0]        shifted;
    logic [mmra_pkg::DEN_W:0]        trial;
    logic                            fits;

    assign shifted = {rem_reg, num_reg[mmra_pkg::NUM_W-1]};
    assign trial   = shifted - {1'b0, den_reg};
    assign fits    = shifted >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= mmra_pkg::STEP_W'(mmra_pkg::NUM_W - 1);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= numerator;
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end else if (busy_reg) begin
            num_reg <= {num_reg[mmra_pkg::NUM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[mmra_pkg::MEAN_W-2:0], fits};
            rem_reg <= fits ? trial[mmra_pkg::DEN_W-1:0] : shifted[mmra_pkg::DEN_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

>>> sv/min_max_rejected_average_core.sv
`timescale 1ns / 1ps
`default_nettype none
// trimmed mean core: mean of a set with one minimum and one maximum dropped
// depends on mmra_pkg, mmra_accum and mmra_divider
//
// s_ channel: one sample per word in s_tdata, s_tlast marks the last word of a set.
// m_ channel: one word per set, m_tdata is the rounded mean (sum-min-max)/(count-2),
// m_tuser is too_few, set when the set held fewer than three samples (mean 0).
// samples beyond 256 in one set are dropped but s_tlast still closes the set.
// throughput: words are taken one per cycle while the output register is free.
// a last word with three or more samples starts a restoring divide,
// one quotient bit per cycle, and s_tready stays low until the result is loaded
// into the output register.
// m_tvalid rises in the cycle after the last word for too_few, else on the divider's registered done.
// while a result waits and m_tready is low, s_tready is held low, so a stalled
// receiver stalls the input as well.
// reset (aresetn low, synchronous) clears the running stats, the divider and
// the output valid.

module min_max_rejected_average_core (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] sample
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] trimmed_mean
    output logic             m_tuser    // [0] too_few
);

    typedef enum logic {
        ST_ACCUM,
        ST_DIVIDE
    } state_t;

    state_t                           state_reg;
    logic                             m_valid_reg;
    logic [mmra_pkg::MEAN_W-1:0]      m_data_reg;
    logic                             m_user_reg;

    mmra_pkg::stats_t                 stats;
    logic                             s_accept;
    logic                             set_done;
    logic                             few;
    logic                             div_start;
    logic                             div_done;
    logic [mmra_pkg::MEAN_W-1:0]      div_quot;
    logic [mmra_pkg::SUM_W-1:0]       trimmed;
    logic [mmra_pkg::COUNT_W-1:0]     den;
    logic [mmra_pkg::NUM_W-1:0]       numerator;
    logic [mmra_pkg::DEN_W-1:0]       divisor;
    logic                             out_free;

    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_ACCUM) && out_free;
    assign s_accept  = s_tvalid && s_tready;
    assign set_done  = s_accept && s_tlast;
    assign few       = stats.count < mmra_pkg::COUNT_W'(mmra_pkg::MIN_COUNT);
    assign div_start = set_done && !few;

    // rounded half up: (2n + d) / (2d)
    assign trimmed   = stats.sum - mmra_pkg::SUM_W'(stats.min_val)
                                 - mmra_pkg::SUM_W'(stats.max_val);
    assign den       = stats.count - mmra_pkg::COUNT_W'(mmra_pkg::TRIM_COUNT);
    assign numerator = {1'b0, trimmed, 1'b0} + mmra_pkg::NUM_W'(den);
    assign divisor   = {den, 1'b0};

    mmra_accum u_accum (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_accept),
        .last    (s_tlast),
        .sample  (s_tdata[mmra_pkg::SAMPLE_BITS-1:0]),
        .stats   (stats)
    );

    mmra_divider u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .numerator (numerator),
        .divisor   (divisor),
        .done      (div_done),
        .quotient  (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_ACCUM;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            m_user_reg  <= 1'b0;
        end else begin
            case (state_reg)
                ST_ACCUM: begin
                    if (set_done && few) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= '0;
                        m_user_reg  <= 1'b1;
                    end else begin
                        if (m_valid_reg && m_tready) begin
                            m_valid_reg <= 1'b0;
                        end
                        if (set_done) begin
                            state_reg <= ST_DIVIDE;
                        end
                    end
                end
                ST_DIVIDE: begin
                    if (div_done) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= div_quot;
                        m_user_reg  <= 1'b0;
                        state_reg   <= ST_ACCUM;
                    end else if (m_valid_reg && m_tready) begin
                        m_valid_reg <= 1'b0;
                    end
                end
                default: begin
                    state_reg <= ST_ACCUM;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

`default_nettype wire
